// ===== rtl/core/wdfs_pkg.sv =====
`default_nettype none

package wdfs_pkg;

    // Table geometry
    localparam int MAX_FACES  = 16;
    localparam int IDX_W      = $clog2(MAX_FACES);
    localparam int CNT_W      = $clog2(MAX_FACES + 1);
    localparam int MAX_ROUNDS = 8;
    localparam int RND_W      = $clog2(MAX_ROUNDS + 1);

    // Field and arithmetic widths
    localparam int FACE_W  = 16;
    localparam int RATE_W  = 32;
    localparam int BAL_W   = 32;
    localparam int SIZE_W  = 20;
    localparam int QUAN_W  = 24;
    localparam int TOT_W   = 36;
    localparam int PROD_W  = RATE_W + QUAN_W;
    localparam int SHARE_W = RATE_W + 17;

    localparam logic [SIZE_W-1:0]  DEFAULT_SIZE = SIZE_W'(9000);
    localparam logic [16:0]        SHARE_SCALE  = 17'd100000;

    // Register reset values
    localparam logic [QUAN_W-1:0] QUANTUM_RST  = QUAN_W'(9000);
    localparam logic [QUAN_W-1:0] CAP_RST      = QUAN_W'(100000);
    localparam logic [RATE_W-1:0] DEF_RATE_RST = RATE_W'(2000000);

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_QUANTUM  = 2'd0;
    localparam logic [1:0] REG_CAP      = 2'd1;
    localparam logic [1:0] REG_DEF_RATE = 2'd2;
    localparam logic [1:0] REG_ERASE    = 2'd3;

    // Request types
    localparam logic [1:0] REQ_UPDATE = 2'd0;
    localparam logic [1:0] REQ_SELECT = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    // Result status codes
    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_FULL = 2'd1;
    localparam logic [1:0] STS_NONE = 2'd2;

    // Datapath operations
    localparam logic [4:0] OP_NONE        = 5'd0;
    localparam logic [4:0] OP_LOAD        = 5'd1;
    localparam logic [4:0] OP_FIND_STEP   = 5'd2;
    localparam logic [4:0] OP_UPD_HIT     = 5'd3;
    localparam logic [4:0] OP_UPD_APPEND  = 5'd4;
    localparam logic [4:0] OP_RES_FULL    = 5'd5;
    localparam logic [4:0] OP_RES_NONE    = 5'd6;
    localparam logic [4:0] OP_RES_ONE     = 5'd7;
    localparam logic [4:0] OP_ROUND_START = 5'd8;
    localparam logic [4:0] OP_PASS_START  = 5'd9;
    localparam logic [4:0] OP_REFILL_NEXT = 5'd10;
    localparam logic [4:0] OP_MUL         = 5'd11;
    localparam logic [4:0] OP_DIV_START   = 5'd12;
    localparam logic [4:0] OP_REFILL_ADD  = 5'd13;
    localparam logic [4:0] OP_SCAN_HIT    = 5'd14;
    localparam logic [4:0] OP_SCAN_NEXT   = 5'd15;
    localparam logic [4:0] OP_TICK_STEP   = 5'd16;
    localparam logic [4:0] OP_TICK_END    = 5'd17;
    localparam logic [4:0] OP_OUT         = 5'd18;

    typedef struct packed {
        logic [4:0] op;
        logic       use_scan;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       idx_end;
        logic       id_match;
        logic       count_zero;
        logic       count_one;
        logic       count_full;
        logic       scan_end;
        logic       rounds_spent;
        logic       bal_ge_cap;
        logic       scan_hit;
        logic       skipped_all;
        logic       div_done;
        logic       out_free;
    } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/weighted_deficit_face_selector_unit.sv =====
`default_nettype none

// Weighted deficit face selector.
// Request channel s_*: one transfer carries an update, a select or a tick.
// Result channel m_*: exactly one result transfer per request, in order.
// Registers quantum, balance_cap, default_rate, erase_silent sit on the
// APB port at byte addresses 0, 4, 8, 12; write them only while idle.
// One request is worked at a time by a controller sequencing one table
// read per cycle, except while it waits on the divider or the output.
// An update searches at most 16 entries; a tick visits every entry.
// A select with one or no entry needs no scan. Otherwise a select scans
// entries and, per refill round, refills each entry below the cap
// through the 24-step credit divider, for at most 8 rounds.
// A new request is taken while the previous result still waits in the
// output register; if the receiver stalls, the finished second result
// holds inside until the output register frees.
// Reset empties the table, zeroes the total rate and scan pointer, and
// loads the register defaults; the table needs no clearing pass.
module weighted_deficit_face_selector_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [1:0]   s_req_type,
    input  wire logic [15:0]  s_face_id,
    input  wire logic [31:0]  s_rate,
    input  wire logic [19:0]  s_data_size,
    input  wire logic         s_has_size,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [15:0]       m_selected_face,
    output logic              m_new_entry,
    output logic [1:0]        m_status
);

    wdfs_pkg::cmd_t  cmd;
    wdfs_pkg::stat_t stat;

    assign pready = 1'b1;

    wdfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    wdfs_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .s_req_type      (s_req_type),
        .s_face_id       (s_face_id),
        .s_rate          (s_rate),
        .s_data_size     (s_data_size),
        .s_has_size      (s_has_size),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_selected_face (m_selected_face),
        .m_new_entry     (m_new_entry),
        .m_status        (m_status),
        .cmd             (cmd),
        .stat            (stat)
    );

endmodule

`default_nettype wire

// ===== rtl/core/wdfs_div.sv =====
`default_nettype none

module wdfs_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [wdfs_pkg::PROD_W-1:0]   dividend,
    input  wire logic [wdfs_pkg::TOT_W-1:0]    divisor,
    output logic                               done,
    output logic [wdfs_pkg::QUAN_W-1:0]        quotient
);

    // Quotient is known to fit QUAN_W bits, so only that many steps run
    logic [wdfs_pkg::TOT_W-1:0]  rem_reg;
    logic [wdfs_pkg::QUAN_W-1:0] low_reg;
    logic [4:0]                  cnt_reg;
    logic                        busy_reg;
    logic [wdfs_pkg::TOT_W:0]    trial;
    logic                        ge;

    assign trial = {rem_reg, low_reg[wdfs_pkg::QUAN_W-1]};
    assign ge    = trial >= {1'b0, divisor};

    // Control: one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'(wdfs_pkg::QUAN_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Restoring shift-subtract
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= wdfs_pkg::TOT_W'(dividend[wdfs_pkg::PROD_W-1:wdfs_pkg::QUAN_W]);
            low_reg <= dividend[wdfs_pkg::QUAN_W-1:0];
        end else if (busy_reg) begin
            rem_reg <= ge ? wdfs_pkg::TOT_W'(trial - {1'b0, divisor})
                          : trial[wdfs_pkg::TOT_W-1:0];
            low_reg <= {low_reg[wdfs_pkg::QUAN_W-2:0], ge};
        end
    end

    assign done     = !busy_reg;
    assign quotient = low_reg;

endmodule

`default_nettype wire

// ===== rtl/core/wdfs_dp.sv =====
`default_nettype none

module wdfs_dp (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [3:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    // request fields
    input  wire logic [1:0]                   s_req_type,
    input  wire logic [wdfs_pkg::FACE_W-1:0]  s_face_id,
    input  wire logic [wdfs_pkg::RATE_W-1:0]  s_rate,
    input  wire logic [wdfs_pkg::SIZE_W-1:0]  s_data_size,
    input  wire logic                         s_has_size,
    // result channel
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [wdfs_pkg::FACE_W-1:0]       m_selected_face,
    output logic                              m_new_entry,
    output logic [1:0]                        m_status,
    // control
    input  wire wdfs_pkg::cmd_t               cmd,
    output wdfs_pkg::stat_t                   stat
);

    localparam int IDX_W = wdfs_pkg::IDX_W;
    localparam int CNT_W = wdfs_pkg::CNT_W;
    localparam int TOT_W = wdfs_pkg::TOT_W;

    // Configuration registers
    logic [wdfs_pkg::QUAN_W-1:0] quantum_reg;
    logic [wdfs_pkg::QUAN_W-1:0] cap_reg;
    logic [wdfs_pkg::RATE_W-1:0] def_rate_reg;
    logic                        erase_reg;

    // Face table
    logic [wdfs_pkg::FACE_W-1:0] face_mem  [wdfs_pkg::MAX_FACES];
    logic [wdfs_pkg::RATE_W-1:0] rate_mem  [wdfs_pkg::MAX_FACES];
    logic [wdfs_pkg::BAL_W-1:0]  bal_mem   [wdfs_pkg::MAX_FACES];
    logic                        heard_mem [wdfs_pkg::MAX_FACES];

    logic [CNT_W-1:0]            count_reg;
    logic [TOT_W-1:0]            total_reg;
    logic [CNT_W-1:0]            scan_reg;

    // Working registers
    logic [CNT_W-1:0]            idx_reg;
    logic [CNT_W-1:0]            wr_reg;
    logic [wdfs_pkg::RND_W-1:0]  rounds_reg;
    logic [CNT_W-1:0]            skipped_reg;
    logic [wdfs_pkg::PROD_W-1:0] prod_reg;
    logic [1:0]                  req_type_reg;
    logic [wdfs_pkg::FACE_W-1:0] req_face_reg;
    logic [wdfs_pkg::RATE_W-1:0] req_rate_reg;
    logic [wdfs_pkg::SIZE_W-1:0] req_size_reg;

    logic [wdfs_pkg::FACE_W-1:0] res_face_reg;
    logic                        res_new_reg;
    logic [1:0]                  res_status_reg;

    logic                        m_valid_reg;
    logic [wdfs_pkg::FACE_W-1:0] m_face_reg;
    logic                        m_new_reg;
    logic [1:0]                  m_status_reg;

    // Read port
    logic [IDX_W-1:0]            rd_addr;
    logic [wdfs_pkg::FACE_W-1:0] rd_face;
    logic [wdfs_pkg::RATE_W-1:0] rd_rate;
    logic [wdfs_pkg::BAL_W-1:0]  rd_bal;
    logic                        rd_heard;
    logic [wdfs_pkg::SHARE_W-1:0] share_prod;
    logic                        low_share;
    logic                        tot_zero;
    logic                        div_done;
    logic [wdfs_pkg::QUAN_W-1:0] div_q;
    logic                        cfg_wr;

    assign rd_addr  = cmd.use_scan ? scan_reg[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    assign rd_face  = face_mem[rd_addr];
    assign rd_rate  = rate_mem[rd_addr];
    assign rd_bal   = bal_mem[rd_addr];
    assign rd_heard = heard_mem[rd_addr];

    assign share_prod = wdfs_pkg::SHARE_W'(rd_rate) * wdfs_pkg::SHARE_W'(wdfs_pkg::SHARE_SCALE);
    assign low_share  = share_prod < wdfs_pkg::SHARE_W'(total_reg);
    assign tot_zero   = total_reg == '0;

    // Credit divider
    wdfs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.op == wdfs_pkg::OP_DIV_START),
        .dividend (tot_zero ? wdfs_pkg::PROD_W'(quantum_reg) : prod_reg),
        .divisor  (tot_zero ? TOT_W'(count_reg) : total_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Status to controller
    always_comb begin
        stat.req_type     = req_type_reg;
        stat.idx_end      = idx_reg >= count_reg;
        stat.id_match     = rd_face == req_face_reg;
        stat.count_zero   = count_reg == '0;
        stat.count_one    = count_reg == CNT_W'(1);
        stat.count_full   = count_reg >= CNT_W'(wdfs_pkg::MAX_FACES);
        stat.scan_end     = scan_reg >= count_reg;
        stat.rounds_spent = rounds_reg >= wdfs_pkg::RND_W'(wdfs_pkg::MAX_ROUNDS);
        stat.bal_ge_cap   = rd_bal >= wdfs_pkg::BAL_W'(cap_reg);
        stat.scan_hit     = (rd_bal > wdfs_pkg::BAL_W'(req_size_reg))
                            && (rd_face != req_face_reg);
        stat.skipped_all  = skipped_reg >= count_reg;
        stat.div_done     = div_done;
        stat.out_free     = !m_valid_reg || m_ready;
    end

    // Configuration port
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quantum_reg  <= wdfs_pkg::QUANTUM_RST;
            cap_reg      <= wdfs_pkg::CAP_RST;
            def_rate_reg <= wdfs_pkg::DEF_RATE_RST;
            erase_reg    <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                wdfs_pkg::REG_QUANTUM:  quantum_reg  <= pwdata[wdfs_pkg::QUAN_W-1:0];
                wdfs_pkg::REG_CAP:      cap_reg      <= pwdata[wdfs_pkg::QUAN_W-1:0];
                wdfs_pkg::REG_DEF_RATE: def_rate_reg <= pwdata;
                wdfs_pkg::REG_ERASE:    erase_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            wdfs_pkg::REG_QUANTUM:  prdata = 32'(quantum_reg);
            wdfs_pkg::REG_CAP:      prdata = 32'(cap_reg);
            wdfs_pkg::REG_DEF_RATE: prdata = def_rate_reg;
            wdfs_pkg::REG_ERASE:    prdata = 32'(erase_reg);
            default:                prdata = '0;
        endcase
    end

    // Table state: count, total and scan pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            total_reg <= '0;
            scan_reg  <= '0;
        end else begin
            case (cmd.op)
                wdfs_pkg::OP_UPD_HIT: begin
                    total_reg <= total_reg - TOT_W'(rd_rate) + TOT_W'(req_rate_reg);
                end
                wdfs_pkg::OP_UPD_APPEND: begin
                    count_reg <= count_reg + CNT_W'(1);
                    total_reg <= total_reg + TOT_W'(req_rate_reg);
                end
                wdfs_pkg::OP_ROUND_START: scan_reg <= '0;
                wdfs_pkg::OP_SCAN_NEXT:   scan_reg <= scan_reg + CNT_W'(1);
                wdfs_pkg::OP_TICK_STEP: begin
                    if (!rd_heard && erase_reg) begin
                        total_reg <= total_reg - TOT_W'(rd_rate);
                    end else if (!rd_heard) begin
                        total_reg <= total_reg - TOT_W'(rd_rate) + TOT_W'(def_rate_reg);
                    end
                end
                wdfs_pkg::OP_TICK_END: count_reg <= wr_reg;
                default: ;
            endcase
        end
    end

    // Table entries: one write per cycle
    always_ff @(posedge aclk) begin
        case (cmd.op)
            wdfs_pkg::OP_UPD_HIT: begin
                rate_mem[rd_addr]  <= req_rate_reg;
                heard_mem[rd_addr] <= 1'b1;
            end
            wdfs_pkg::OP_UPD_APPEND: begin
                face_mem[count_reg[IDX_W-1:0]]  <= req_face_reg;
                rate_mem[count_reg[IDX_W-1:0]]  <= req_rate_reg;
                bal_mem[count_reg[IDX_W-1:0]]   <= '0;
                heard_mem[count_reg[IDX_W-1:0]] <= 1'b1;
            end
            wdfs_pkg::OP_REFILL_ADD: begin
                bal_mem[rd_addr] <= rd_bal + wdfs_pkg::BAL_W'(div_q);
            end
            wdfs_pkg::OP_SCAN_HIT: begin
                bal_mem[rd_addr] <= rd_bal - wdfs_pkg::BAL_W'(req_size_reg);
            end
            wdfs_pkg::OP_TICK_STEP: begin
                if (rd_heard || !erase_reg) begin
                    face_mem[wr_reg[IDX_W-1:0]]  <= rd_face;
                    bal_mem[wr_reg[IDX_W-1:0]]   <= rd_bal;
                    rate_mem[wr_reg[IDX_W-1:0]]  <= rd_heard ? rd_rate : def_rate_reg;
                    heard_mem[wr_reg[IDX_W-1:0]] <= !rd_heard;
                end
            end
            default: ;
        endcase
    end

    // Per-item working registers and result
    always_ff @(posedge aclk) begin
        case (cmd.op)
            wdfs_pkg::OP_LOAD: begin
                req_type_reg   <= s_req_type;
                req_face_reg   <= s_face_id;
                req_rate_reg   <= s_rate;
                req_size_reg   <= s_has_size ? s_data_size : wdfs_pkg::DEFAULT_SIZE;
                idx_reg        <= '0;
                wr_reg         <= '0;
                rounds_reg     <= '0;
                skipped_reg    <= '0;
                res_face_reg   <= '0;
                res_new_reg    <= 1'b0;
                res_status_reg <= wdfs_pkg::STS_OK;
            end
            wdfs_pkg::OP_FIND_STEP:  idx_reg <= idx_reg + CNT_W'(1);
            wdfs_pkg::OP_UPD_APPEND: res_new_reg <= 1'b1;
            wdfs_pkg::OP_RES_FULL:   res_status_reg <= wdfs_pkg::STS_FULL;
            wdfs_pkg::OP_RES_NONE: begin
                res_face_reg   <= '0;
                res_status_reg <= wdfs_pkg::STS_NONE;
            end
            wdfs_pkg::OP_RES_ONE: res_face_reg <= rd_face;
            wdfs_pkg::OP_ROUND_START: begin
                rounds_reg  <= rounds_reg + wdfs_pkg::RND_W'(1);
                idx_reg     <= '0;
                skipped_reg <= '0;
            end
            wdfs_pkg::OP_PASS_START:  skipped_reg <= '0;
            wdfs_pkg::OP_REFILL_NEXT: idx_reg <= idx_reg + CNT_W'(1);
            wdfs_pkg::OP_MUL:         prod_reg <= rd_rate * quantum_reg;
            wdfs_pkg::OP_REFILL_ADD:  idx_reg <= idx_reg + CNT_W'(1);
            wdfs_pkg::OP_SCAN_HIT:    res_face_reg <= rd_face;
            wdfs_pkg::OP_SCAN_NEXT: begin
                if (!stat.id_match && !low_share) begin
                    skipped_reg <= skipped_reg;
                end else begin
                    skipped_reg <= skipped_reg + CNT_W'(1);
                end
            end
            wdfs_pkg::OP_TICK_STEP: begin
                idx_reg <= idx_reg + CNT_W'(1);
                if (rd_heard || !erase_reg) begin
                    wr_reg <= wr_reg + CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    // Output register: hold until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.op == wdfs_pkg::OP_OUT) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == wdfs_pkg::OP_OUT) begin
            m_face_reg   <= res_face_reg;
            m_new_reg    <= res_new_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_selected_face = m_face_reg;
    assign m_new_entry     = m_new_reg;
    assign m_status        = m_status_reg;

endmodule

`default_nettype wire

// ===== rtl/core/wdfs_ctrl.sv =====
`default_nettype none

module wdfs_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire wdfs_pkg::stat_t  stat,
    output wdfs_pkg::cmd_t        cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DISPATCH = 4'd1;
    localparam logic [3:0] ST_FIND     = 4'd2;
    localparam logic [3:0] ST_SEL0     = 4'd3;
    localparam logic [3:0] ST_OUTER    = 4'd4;
    localparam logic [3:0] ST_REFILL   = 4'd5;
    localparam logic [3:0] ST_DIVGO    = 4'd6;
    localparam logic [3:0] ST_DIVWAIT  = 4'd7;
    localparam logic [3:0] ST_SCAN     = 4'd8;
    localparam logic [3:0] ST_TICK     = 4'd9;
    localparam logic [3:0] ST_DONE     = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = state_reg == ST_IDLE;

    // Sequence the datapath
    always_comb begin
        state_next   = state_reg;
        cmd.op       = wdfs_pkg::OP_NONE;
        cmd.use_scan = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = wdfs_pkg::OP_LOAD;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (stat.req_type)
                    wdfs_pkg::REQ_UPDATE: state_next = ST_FIND;
                    wdfs_pkg::REQ_SELECT: state_next = ST_SEL0;
                    wdfs_pkg::REQ_TICK:   state_next = ST_TICK;
                    default:              state_next = ST_DONE;
                endcase
            end
            ST_FIND: begin
                if (stat.idx_end) begin
                    cmd.op     = stat.count_full ? wdfs_pkg::OP_RES_FULL
                                                 : wdfs_pkg::OP_UPD_APPEND;
                    state_next = ST_DONE;
                end else if (stat.id_match) begin
                    cmd.op     = wdfs_pkg::OP_UPD_HIT;
                    state_next = ST_DONE;
                end else begin
                    cmd.op = wdfs_pkg::OP_FIND_STEP;
                end
            end
            ST_SEL0: begin
                if (stat.count_zero || (stat.count_one && stat.id_match)) begin
                    cmd.op     = wdfs_pkg::OP_RES_NONE;
                    state_next = ST_DONE;
                end else if (stat.count_one) begin
                    cmd.op     = wdfs_pkg::OP_RES_ONE;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_OUTER;
                end
            end
            ST_OUTER: begin
                if (stat.scan_end && stat.rounds_spent) begin
                    cmd.op     = wdfs_pkg::OP_RES_NONE;
                    state_next = ST_DONE;
                end else if (stat.scan_end) begin
                    cmd.op     = wdfs_pkg::OP_ROUND_START;
                    state_next = ST_REFILL;
                end else begin
                    cmd.op     = wdfs_pkg::OP_PASS_START;
                    state_next = ST_SCAN;
                end
            end
            ST_REFILL: begin
                if (stat.idx_end) begin
                    state_next = ST_SCAN;
                end else if (stat.bal_ge_cap) begin
                    cmd.op = wdfs_pkg::OP_REFILL_NEXT;
                end else begin
                    cmd.op     = wdfs_pkg::OP_MUL;
                    state_next = ST_DIVGO;
                end
            end
            ST_DIVGO: begin
                cmd.op     = wdfs_pkg::OP_DIV_START;
                state_next = ST_DIVWAIT;
            end
            ST_DIVWAIT: begin
                if (stat.div_done) begin
                    cmd.op     = wdfs_pkg::OP_REFILL_ADD;
                    state_next = ST_REFILL;
                end
            end
            ST_SCAN: begin
                cmd.use_scan = 1'b1;
                if (stat.scan_end) begin
                    if (stat.skipped_all) begin
                        cmd.op     = wdfs_pkg::OP_RES_NONE;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_OUTER;
                    end
                end else if (stat.scan_hit) begin
                    cmd.op     = wdfs_pkg::OP_SCAN_HIT;
                    state_next = ST_DONE;
                end else begin
                    cmd.op = wdfs_pkg::OP_SCAN_NEXT;
                end
            end
            ST_TICK: begin
                if (stat.idx_end) begin
                    cmd.op     = wdfs_pkg::OP_TICK_END;
                    state_next = ST_DONE;
                end else begin
                    cmd.op = wdfs_pkg::OP_TICK_STEP;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.op     = wdfs_pkg::OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== bench/weighted_deficit_face_selector_unit_test.sv =====
`timescale 1ns / 1ps

module weighted_deficit_face_selector_unit_test;

    localparam logic [1:0] REQ_RESERVED = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_req_type;
    logic [15:0] s_face_id;
    logic [31:0] s_rate;
    logic [19:0] s_data_size;
    logic        s_has_size;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_selected_face;
    logic        m_new_entry;
    logic [1:0]  m_status;

    weighted_deficit_face_selector_unit dut (.*);

    typedef struct {
        logic [15:0] face;
        logic        fresh;
        logic [1:0]  status;
    } decision_t;

    // predictor state
    logic [23:0] quantum_q;
    logic [23:0] cap_q;
    logic [31:0] def_rate_q;
    logic        erase_q;
    logic [15:0] tbl_face[wdfs_pkg::MAX_FACES];
    logic [31:0] tbl_rate[wdfs_pkg::MAX_FACES];
    logic [31:0] tbl_bal[wdfs_pkg::MAX_FACES];
    logic        tbl_heard[wdfs_pkg::MAX_FACES];
    int          face_count;
    logic [35:0] rate_sum;
    int          scan_pos;

    decision_t   pending_decisions[$];
    int          fail_count;
    int          send_idle_pct;
    int          recv_stall_pct;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic void credit_round();
        logic [63:0] credit;
        for (int i = 0; i < face_count; i++) begin
            if (tbl_bal[i] < {8'd0, cap_q}) begin
                if (rate_sum == 0)
                    credit = 64'(quantum_q) / 64'(face_count);
                else
                    credit = (64'(tbl_rate[i]) * 64'(quantum_q)) / 64'(rate_sum);
                tbl_bal[i] = tbl_bal[i] + credit[31:0];
            end
        end
        scan_pos = 0;
    endfunction

    function automatic void pick_face(input logic [15:0] excl, input logic [19:0] size,
                                      output decision_t d);
        int rounds;
        int skipped;
        rounds = 0;
        d.face = '0;
        d.fresh = 1'b0;
        d.status = wdfs_pkg::STS_OK;
        if (face_count == 0) begin
            d.status = wdfs_pkg::STS_NONE;
            return;
        end
        if (face_count == 1) begin
            if (tbl_face[0] == excl) d.status = wdfs_pkg::STS_NONE;
            else d.face = tbl_face[0];
            return;
        end
        forever begin
            skipped = 0;
            if (scan_pos >= face_count) begin
                if (rounds >= wdfs_pkg::MAX_ROUNDS) begin
                    d.status = wdfs_pkg::STS_NONE;
                    return;
                end
                credit_round();
                rounds++;
            end
            for (; scan_pos < face_count; scan_pos++) begin
                if (tbl_bal[scan_pos] > {12'd0, size} && tbl_face[scan_pos] != excl) begin
                    tbl_bal[scan_pos] -= {12'd0, size};
                    d.face = tbl_face[scan_pos];
                    return;
                end
                if (tbl_face[scan_pos] == excl ||
                    64'(tbl_rate[scan_pos]) * 64'(wdfs_pkg::SHARE_SCALE) < 64'(rate_sum))
                    skipped++;
            end
            if (skipped >= face_count) begin
                d.status = wdfs_pkg::STS_NONE;
                return;
            end
        end
    endfunction

    function automatic decision_t predict_decision(logic [1:0] req, logic [15:0] id,
                                                    logic [31:0] rate, logic [19:0] size,
                                                    logic has);
        decision_t d;
        int k;
        int w;
        d.face = '0;
        d.fresh = 1'b0;
        d.status = wdfs_pkg::STS_OK;
        k = -1;
        w = 0;
        case (req)
            wdfs_pkg::REQ_UPDATE: begin
                for (int i = 0; i < face_count; i++)
                    if (k < 0 && tbl_face[i] == id) k = i;
                if (k >= 0) begin
                    rate_sum = rate_sum - tbl_rate[k] + rate;
                    tbl_rate[k] = rate;
                    tbl_heard[k] = 1'b1;
                end else if (face_count >= wdfs_pkg::MAX_FACES) begin
                    d.status = wdfs_pkg::STS_FULL;
                end else begin
                    tbl_face[face_count] = id;
                    tbl_rate[face_count] = rate;
                    tbl_bal[face_count] = '0;
                    tbl_heard[face_count] = 1'b1;
                    face_count++;
                    rate_sum += rate;
                    d.fresh = 1'b1;
                end
            end
            wdfs_pkg::REQ_SELECT: pick_face(id, has ? size : wdfs_pkg::DEFAULT_SIZE, d);
            wdfs_pkg::REQ_TICK: begin
                for (int i = 0; i < face_count; i++) begin
                    if (tbl_heard[i]) begin
                        tbl_heard[i] = 1'b0;
                    end else if (erase_q) begin
                        rate_sum -= tbl_rate[i];
                        continue;
                    end else begin
                        rate_sum = rate_sum - tbl_rate[i] + def_rate_q;
                        tbl_rate[i] = def_rate_q;
                        tbl_heard[i] = 1'b1;
                    end
                    tbl_face[w] = tbl_face[i];
                    tbl_rate[w] = tbl_rate[i];
                    tbl_bal[w] = tbl_bal[i];
                    tbl_heard[w] = tbl_heard[i];
                    w++;
                end
                face_count = w;
            end
            default: ;
        endcase
        return d;
    endfunction

    // send one request, predicting its result at the transfer
    task automatic send_request(logic [1:0] req, logic [15:0] id, logic [31:0] rate,
                                logic [19:0] size, logic has);
        decision_t d;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= req;
        s_face_id <= id;
        s_rate <= rate;
        s_data_size <= size;
        s_has_size <= has;
        do @(posedge aclk); while (!s_ready);
        d = predict_decision(req, id, rate, size, has);
        pending_decisions = {pending_decisions, d};
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_decisions.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            wdfs_pkg::REG_QUANTUM: quantum_q = value[23:0];
            wdfs_pkg::REG_CAP: cap_q = value[23:0];
            wdfs_pkg::REG_DEF_RATE: def_rate_q = value;
            wdfs_pkg::REG_ERASE: erase_q = value[0];
            default: ;
        endcase
    endtask

    // compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        decision_t d;
        if (aresetn && m_valid && m_ready) begin
            if (pending_decisions.size() == 0) begin
                $error("unexpected result face %0d", m_selected_face);
                fail_count++;
            end else begin
                d = pending_decisions.pop_front();
                if (m_selected_face !== d.face) begin
                    $error("selected_face expected %0d got %0d", d.face, m_selected_face);
                    fail_count++;
                end
                if (m_new_entry !== d.fresh) begin
                    $error("new_entry expected %0d got %0d", d.fresh, m_new_entry);
                    fail_count++;
                end
                if (m_status !== d.status) begin
                    $error("status expected %0d got %0d", d.status, m_status);
                    fail_count++;
                end
            end
        end
    end

    // stall the result channel at the current rate
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [15:0] some_face();
        return (face_count > 0 && $urandom_range(3) != 0) ?
            tbl_face[$urandom_range(face_count - 1)] : 16'($urandom_range(40));
    endfunction

    task automatic test_directed_edges();
        send_request(wdfs_pkg::REQ_SELECT, 16'd0, '0, '0, 1'b0);
        send_request(wdfs_pkg::REQ_UPDATE, 16'd0, 32'd0, '0, 1'b0);
        send_request(wdfs_pkg::REQ_SELECT, 16'd0, '0, '0, 1'b0);
        send_request(wdfs_pkg::REQ_SELECT, 16'd7, '0, 20'hFFFFF, 1'b1);
        send_request(wdfs_pkg::REQ_UPDATE, 16'hFFFF, 32'hFFFFFFFF, '0, 1'b0);
        send_request(wdfs_pkg::REQ_UPDATE, 16'h5555, 32'd1, '0, 1'b0);
        send_request(wdfs_pkg::REQ_SELECT, 16'hAAAA, '0, 20'd0, 1'b1);
        send_request(wdfs_pkg::REQ_SELECT, 16'hFFFF, '0, 20'd10, 1'b1);
        send_request(wdfs_pkg::REQ_SELECT, 16'd3, '0, 20'hFFFFF, 1'b1);
        send_request(REQ_RESERVED, 16'hFFFF, 32'hFFFFFFFF, 20'hFFFFF, 1'b1);
        for (int i = 1; i <= 16; i++)
            send_request(wdfs_pkg::REQ_UPDATE, 16'(i * 3), 32'(i * 1000), '0, 1'b0);
        send_request(wdfs_pkg::REQ_TICK, '0, '0, '0, 1'b0);
        send_request(wdfs_pkg::REQ_SELECT, 16'd0, '0, 20'd100, 1'b1);
        drain_results();
    endtask

    task automatic run_random(int count);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 30)
                send_request(wdfs_pkg::REQ_UPDATE, some_face(),
                             $urandom_range(3) == 0 ? $urandom() : 32'($urandom_range(5000000)),
                             20'($urandom()), 1'($urandom()));
            else if (r < 88)
                send_request(wdfs_pkg::REQ_SELECT, some_face(), $urandom(),
                             $urandom_range(3) == 0 ? 20'($urandom()) :
                             20'($urandom_range(12000)), 1'($urandom()));
            else if (r < 97)
                send_request(wdfs_pkg::REQ_TICK, 16'($urandom()), $urandom(),
                             20'($urandom()), 1'($urandom()));
            else
                send_request(REQ_RESERVED, 16'($urandom()), $urandom(), 20'($urandom()),
                             1'($urandom()));
        end
        drain_results();
    endtask

    task automatic test_config_sweep();
        write_register(wdfs_pkg::REG_QUANTUM, 32'd1);
        write_register(wdfs_pkg::REG_CAP, 32'hFFFFFF);
        write_register(wdfs_pkg::REG_DEF_RATE, 32'd0);
        write_register(wdfs_pkg::REG_ERASE, 32'd1);
        run_random(150);
        write_register(wdfs_pkg::REG_QUANTUM, 32'hFFFFFF);
        write_register(wdfs_pkg::REG_CAP, 32'd1);
        write_register(wdfs_pkg::REG_DEF_RATE, 32'hFFFFFFFF);
        write_register(wdfs_pkg::REG_ERASE, 32'd0);
        run_random(150);
        write_register(wdfs_pkg::REG_QUANTUM, 32'd30000);
        write_register(wdfs_pkg::REG_CAP, 32'd200000);
        write_register(wdfs_pkg::REG_DEF_RATE, 32'd2000000);
        write_register(wdfs_pkg::REG_ERASE, 32'd1);
        run_random(150);
    endtask

    task automatic test_flow_phases();
        write_register(wdfs_pkg::REG_ERASE, 32'd0);
        send_idle_pct = 0;  recv_stall_pct = 0;  run_random(250);
        send_idle_pct = 66; recv_stall_pct = 0;  run_random(250);
        send_idle_pct = 0;  recv_stall_pct = 66; run_random(250);
        send_idle_pct = 14; recv_stall_pct = 14; run_random(250);
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_req_type = '0;
        s_face_id = '0;
        s_rate = '0;
        s_data_size = '0;
        s_has_size = 1'b0;
        m_ready = 1'b0;
        fail_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        quantum_q = wdfs_pkg::QUANTUM_RST;
        cap_q = wdfs_pkg::CAP_RST;
        def_rate_q = wdfs_pkg::DEF_RATE_RST;
        erase_q = 1'b0;
        face_count = 0;
        rate_sum = '0;
        scan_pos = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_edges();
        test_config_sweep();
        test_flow_phases();

        if (fail_count == 0)
            $display("weighted_deficit_face_selector_unit_test passed");
        else
            $display("weighted_deficit_face_selector_unit_test failed");
        $finish;
    end

    // hard limit on run time
    initial begin
        #200ms;
        $display("weighted_deficit_face_selector_unit_test failed");
        $finish;
    end

endmodule
